FILE: hdl/rpi_pkg.sv
// Shared types, constants and fixed-point helpers for the ray/polygon intersect block.
`timescale 1ns / 1ps
package rpi_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int COORD_WIDTH = 32;
   localparam int TAG_WIDTH   = 16;
   localparam int IW          = COORD_WIDTH + 4;   // inner saturated width
   localparam int DW          = COORD_WIDTH + 1;   // coordinate difference width
   localparam int MW          = 2 * DW;            // full product width
   localparam int AW          = IW + 2;            // accumulator width
   localparam int CSR_IDX_W   = 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [IW-1:0]          inner_type;
   typedef logic signed [DW-1:0]          diff_type;
   typedef logic signed [AW-1:0]          acc_type;

   localparam inner_type IMAX = {1'b0, {(IW-1){1'b1}}};
   localparam inner_type IMIN = {1'b1, {(IW-1){1'b0}}};
   localparam coord_type CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_HEADER = 2'd1,
      ACT_VERTEX = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_DIR_X    = 3'd3,
      CSR_DIR_Y    = 3'd4,
      CSR_DIR_Z    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_D = 2'd0,
      MUL_N = 2'd1,
      MUL_P = 2'd2
   } mul_mode_type;

   typedef enum logic [1:0] {
      EDGE_SKIP   = 2'd0,
      EDGE_TOGGLE = 2'd1,
      EDGE_SOLVE  = 2'd2
   } edge_kind_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CLEAR, S_HEADER, S_SKIP, S_VERTEX,
      S_DOT_D, S_CHK_D, S_DOT_N, S_CHK_N, S_DIV_T, S_CHK_T, S_PT, S_FIRST_END,
      S_EDGE_EVAL, S_EDGE_MUL, S_EDGE_DIVST, S_EDGE_DIV, S_EDGE_SIDE,
      S_ADVANCE, S_RESP
   } state_type;

   typedef struct packed {
      logic         latch;
      logic         clear;
      logic         header;
      logic         load_first;
      mul_mode_type mul_mode;
      logic         mul_issue;
      logic         acc_take;
      logic         acc_clear;
      logic [1:0]   term;
      logic         chk_d;
      logic         chk_n;
      logic         chk_t;
      logic         set_live;
      logic         edge_sel;
      logic         edge_eval;
      logic         edge_mul;
      logic         edge_div_start;
      logic         edge_side;
      logic         advance;
      logic         commit;
   } cmd_type;

   typedef struct packed {
      logic          await_first;
      logic          live;
      logic          last;
      logic          d_pos;
      logic          n_nz;
      logic          t_ok;
      edge_kind_type edge_kind;
      logic          div_done;
      logic          rsp_busy;
   } stat_type;

   function automatic inner_type sat_inner(input acc_type x);
      if (x > AW'(IMAX)) return IMAX;
      else if (x < AW'(IMIN)) return IMIN;
      else return x[IW-1:0];
   endfunction

   function automatic coord_type sat_coord(input logic signed [IW:0] x);
      if (x > (IW+1)'(CMAX)) return CMAX;
      else if (x < (IW+1)'(CMIN)) return CMIN;
      else return x[COORD_WIDTH-1:0];
   endfunction

   // Values within one LSB of zero count as zero.
   function automatic inner_type squash(input inner_type x);
      if (x == '0 || x == IW'(1) || x == '1) return '0;
      else return x;
   endfunction

   // Turns an unsigned magnitude and a sign into a saturated signed inner value.
   function automatic inner_type to_inner(input logic [MW-1:0] m, input logic neg);
      logic [IW-1:0] low;
      low = {1'b0, m[IW-2:0]};
      if (|m[MW-1:IW-1]) return neg ? IMIN : IMAX;
      else return neg ? inner_type'(-low) : inner_type'(low);
   endfunction

   function automatic logic [DW-1:0] mag_diff(input diff_type x);
      return x[DW-1] ? DW'(-x) : DW'(x);
   endfunction

   function automatic logic [1:0] drop_a1(input logic [1:0] ap);
      return (ap == 2'd0) ? 2'd1 : 2'd0;
   endfunction

   function automatic logic [1:0] drop_a2(input logic [1:0] ap);
      return (ap == 2'd2) ? 2'd1 : 2'd2;
   endfunction

endpackage

FILE: hdl/ray_polygon_intersect.sv
// Top level of the closest-hit ray versus polygon intersect block.
// Clear and header requests are applied directly. A later vertex of a live face tests its
// edge (a dead face skips it); a slope solve adds a multiply and a division. A first vertex
// runs two dot products, a division for t and the hit point; divisions use the shared
// one-bit-per-cycle divider. A last vertex adds its closing edge and a response step.
// One request at a time; synchronous active-high reset sets the ray to +x, best hit none.
`timescale 1ns / 1ps
module ray_polygon_intersect (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [rpi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rpi_pkg::COORD_WIDTH-1:0]   csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_action,
   input  rpi_pkg::coord_type                req_coord_x,
   input  rpi_pkg::coord_type                req_coord_y,
   input  rpi_pkg::coord_type                req_coord_z,
   input  logic                              req_last_vertex,
   input  logic [rpi_pkg::TAG_WIDTH-1:0]     req_face_tag,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_new_best,
   output logic [rpi_pkg::COORD_WIDTH-2:0]   rsp_best_dist,
   output rpi_pkg::coord_type                rsp_best_hit_x,
   output rpi_pkg::coord_type                rsp_best_hit_y,
   output rpi_pkg::coord_type                rsp_best_hit_z,
   output logic [rpi_pkg::TAG_WIDTH-1:0]     rsp_best_face
);
   import rpi_pkg::*;

   // The controller steps through each request; the datapath holds all values.
   // A finished response sits in its own register, so a new request can be
   // taken while the previous response still waits for rsp_ready.
   cmd_type  cmd;
   stat_type stat;

   rpi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rpi_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .req_last_vertex  (req_last_vertex),
      .req_face_tag     (req_face_tag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_new_best     (rsp_new_best),
      .rsp_best_dist    (rsp_best_dist),
      .rsp_best_hit_x   (rsp_best_hit_x),
      .rsp_best_hit_y   (rsp_best_hit_y),
      .rsp_best_hit_z   (rsp_best_hit_z),
      .rsp_best_face    (rsp_best_face)
   );

endmodule

FILE: hdl/rpi_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, saturated signed result.
`timescale 1ns / 1ps
module rpi_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [rpi_pkg::MW-1:0]   num,
   input  logic [rpi_pkg::IW-1:0]   den,
   input  logic                     neg,
   output logic                     done,
   output rpi_pkg::inner_type       quot
);
   import rpi_pkg::*;

   localparam int CW = $clog2(MW + 1);

   logic [CW-1:0]  cnt_ff;
   logic           busy_ff, done_ff, neg_ff;
   logic [MW-1:0]  num_ff, quo_ff;
   logic [IW-1:0]  rem_ff, den_ff;
   logic [IW:0]    trial;
   logic           fits;

   assign trial = {rem_ff, num_ff[MW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(MW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         neg_ff <= neg;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[MW-2:0], 1'b0};
         rem_ff <= fits ? IW'(trial - {1'b0, den_ff}) : trial[IW-1:0];
         quo_ff <= {quo_ff[MW-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = to_inner(quo_ff, neg_ff);

endmodule

FILE: hdl/rpi_ctrl.sv
// Sequencing state machine for header, clear and vertex requests.
`timescale 1ns / 1ps
module rpi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_action,
   output logic              req_ready,
   input  rpi_pkg::stat_type stat,
   output rpi_pkg::cmd_type  cmd
);
   import rpi_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       sel_ff, sel_in;
   logic       is_seq;

   assign is_seq = (state_ff == S_DOT_D) || (state_ff == S_DOT_N) || (state_ff == S_PT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cnt_in   = (is_seq && cnt_ff != 2'd3) ? cnt_ff + 2'd1 : 2'd0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (action_type'(req_action))
                  ACT_CLEAR:  state_in = S_CLEAR;
                  ACT_HEADER: state_in = S_HEADER;
                  ACT_VERTEX: state_in = S_VERTEX;
                  default:    state_in = S_SKIP;
               endcase
            end
         end
         S_CLEAR, S_HEADER, S_SKIP: state_in = S_IDLE;
         S_VERTEX: begin
            if (stat.await_first) state_in = S_DOT_D;
            else if (stat.live) begin
               state_in = S_EDGE_EVAL;
               sel_in   = 1'b0;
            end else state_in = S_ADVANCE;
         end
         S_DOT_D: if (cnt_ff == 2'd3) state_in = S_CHK_D;
         S_CHK_D: state_in = stat.d_pos ? S_DOT_N : S_FIRST_END;
         S_DOT_N: if (cnt_ff == 2'd3) state_in = S_CHK_N;
         S_CHK_N: state_in = stat.n_nz ? S_DIV_T : S_FIRST_END;
         S_DIV_T: if (stat.div_done) state_in = S_CHK_T;
         S_CHK_T: state_in = stat.t_ok ? S_PT : S_FIRST_END;
         S_PT:    if (cnt_ff == 2'd3) state_in = S_FIRST_END;
         S_FIRST_END: state_in = stat.last ? S_RESP : S_IDLE;
         S_EDGE_EVAL: begin
            if (stat.edge_kind == EDGE_SOLVE) state_in = S_EDGE_MUL;
            else state_in = sel_ff ? S_RESP : S_ADVANCE;
         end
         S_EDGE_MUL:   state_in = S_EDGE_DIVST;
         S_EDGE_DIVST: state_in = S_EDGE_DIV;
         S_EDGE_DIV:   if (stat.div_done) state_in = S_EDGE_SIDE;
         S_EDGE_SIDE:  state_in = sel_ff ? S_RESP : S_ADVANCE;
         S_ADVANCE: begin
            if (!stat.last) state_in = S_IDLE;
            else if (stat.live) begin
               state_in = S_EDGE_EVAL;
               sel_in   = 1'b1;
            end else state_in = S_RESP;
         end
         S_RESP: if (!stat.rsp_busy) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.term     = cnt_ff;
      cmd.edge_sel = sel_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         S_CLEAR:  cmd.clear = 1'b1;
         S_HEADER: cmd.header = 1'b1;
         S_VERTEX: cmd.load_first = stat.await_first;
         S_DOT_D, S_DOT_N, S_PT: begin
            cmd.mul_mode  = (state_ff == S_DOT_D) ? MUL_D :
                            (state_ff == S_DOT_N) ? MUL_N : MUL_P;
            cmd.mul_issue = cnt_ff != 2'd3;
            cmd.acc_take  = cnt_ff != 2'd0;
            cmd.acc_clear = cnt_ff == 2'd0;
            cmd.set_live  = (state_ff == S_PT) && (cnt_ff == 2'd3);
         end
         S_CHK_D:      cmd.chk_d = 1'b1;
         S_CHK_N:      cmd.chk_n = 1'b1;
         S_CHK_T:      cmd.chk_t = 1'b1;
         S_EDGE_EVAL:  cmd.edge_eval = 1'b1;
         S_EDGE_MUL:   cmd.edge_mul = 1'b1;
         S_EDGE_DIVST: cmd.edge_div_start = 1'b1;
         S_EDGE_SIDE:  cmd.edge_side = 1'b1;
         S_ADVANCE:    cmd.advance = 1'b1;
         S_RESP:       cmd.commit = !stat.rsp_busy;
         default: ;
      endcase
   end

endmodule

FILE: hdl/rpi_dp.sv
// Datapath: ray and face registers, shared multiplier and divider, edge test, results.
`timescale 1ns / 1ps
module rpi_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  rpi_pkg::cmd_type                  cmd,
   output rpi_pkg::stat_type                 stat,
   input  logic                              csr_write_enable,
   input  logic [rpi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rpi_pkg::COORD_WIDTH-1:0]   csr_write_data,
   input  rpi_pkg::coord_type                req_coord_x,
   input  rpi_pkg::coord_type                req_coord_y,
   input  rpi_pkg::coord_type                req_coord_z,
   input  logic                              req_last_vertex,
   input  logic [rpi_pkg::TAG_WIDTH-1:0]     req_face_tag,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_new_best,
   output logic [rpi_pkg::COORD_WIDTH-2:0]   rsp_best_dist,
   output rpi_pkg::coord_type                rsp_best_hit_x,
   output rpi_pkg::coord_type                rsp_best_hit_y,
   output rpi_pkg::coord_type                rsp_best_hit_z,
   output logic [rpi_pkg::TAG_WIDTH-1:0]     rsp_best_face
);
   import rpi_pkg::*;

   coord_type origin_ff [3];
   coord_type dir_ff    [3];
   coord_type normal_ff [3];
   coord_type cur_ff    [3];
   coord_type first_ff  [3];
   coord_type prev_ff   [3];
   coord_type point_ff  [3];
   coord_type best_pt_ff[3];

   logic [TAG_WIDTH-1:0]   in_tag_ff, cur_tag_ff, best_tag_ff;
   logic [COORD_WIDTH-2:0] best_dist_ff;
   logic                   last_ff, parity_ff, live_ff, await_ff;
   logic [1:0]             axis_ff;
   inner_type              dist_ff;
   logic [MW-1:0]          prod_ff;
   logic                   prod_neg_ff;
   acc_type                acc_ff;

   // Dominant axis of the normal being latched, kept until the header step applies it.
   // The dominant axis is picked from the magnitudes of the request coordinates at accept.
   logic [1:0]             axis_next_ff;

   logic                   rsp_valid_ff, rsp_new_best_ff;
   logic [COORD_WIDTH-2:0] rsp_dist_ff;
   coord_type              rsp_pt_ff [3];
   logic [TAG_WIDTH-1:0]   rsp_tag_ff;

   // multiplier operands
   logic [1:0] ki, ti;
   diff_type   ma, mb;
   inner_type  fm, acc_sq;

   // edge operands
   coord_type vi [3];
   coord_type vj [3];
   logic [1:0] a1, a2;
   coord_type vi1, vi2, vj1, vj2, p1, p2;
   diff_type  ea, eb, ec, ed;
   edge_kind_type kind;
   logic      outside, j_before, hit;
   acc_type   side;
   logic [COORD_WIDTH-1:0] amx, amy, amz;

   // divider
   logic          div_start, div_neg, div_done;
   logic [MW-1:0] div_num;
   logic [IW-1:0] div_den;
   inner_type     quot;

   rpi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .neg   (div_neg),
      .done  (div_done),
      .quot  (quot)
   );

   assign ki     = (cmd.term == 2'd3) ? 2'd0 : cmd.term;
   assign ti     = cmd.term - 2'd1;
   assign fm     = to_inner(prod_ff >> FRAC_BITS, prod_neg_ff);
   assign acc_sq = squash(sat_inner(acc_ff));

   always_comb begin
      if (cmd.edge_mul) begin
         ma = ea;
         mb = eb;
      end else begin
         unique case (cmd.mul_mode)
            MUL_D: begin
               ma = DW'(normal_ff[ki]);
               mb = DW'(origin_ff[ki]) - DW'(cur_ff[ki]);
            end
            MUL_N: begin
               ma = DW'(normal_ff[ki]);
               mb = DW'(dir_ff[ki]);
            end
            MUL_P: begin
               ma = DW'(dir_ff[ki]);
               mb = dist_ff[DW-1:0];
            end
            default: begin
               ma = '0;
               mb = '0;
            end
         endcase
      end
   end

   // Edge test in the plane that drops the dominant normal axis.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vi[k] = cmd.edge_sel ? cur_ff[k] : prev_ff[k];
         vj[k] = cmd.edge_sel ? first_ff[k] : cur_ff[k];
      end
      a1  = drop_a1(axis_ff);
      a2  = drop_a2(axis_ff);
      vi1 = vi[a1];
      vi2 = vi[a2];
      vj1 = vj[a1];
      vj2 = vj[a2];
      p1  = point_ff[a1];
      p2  = point_ff[a2];
      ea  = DW'(vj2) - DW'(p2);
      eb  = DW'(vj1) - DW'(vi1);
      ec  = DW'(vj2) - DW'(vi2);
      ed  = DW'(vj1) - DW'(p1);
      outside  = (p2 <= vi2) ^ (vj2 < p2);
      j_before = vj1 < p1;
      if (vi2 == vj2 || outside) kind = EDGE_SKIP;
      else if (p1 <= vi1 && !j_before) kind = EDGE_SKIP;
      else if (p1 > vi1 && j_before) kind = EDGE_TOGGLE;
      else kind = EDGE_SOLVE;
      side = AW'(quot) - AW'(ed);
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = prod_ff;
      div_den   = IW'(mag_diff(ec));
      div_neg   = prod_neg_ff ^ ec[DW-1];
      if (cmd.chk_n) begin
         div_start = acc_sq != '0;
         div_num   = MW'(unsigned'(dist_ff)) << FRAC_BITS;
         div_den   = acc_sq[IW-1] ? IW'(-acc_sq) : IW'(acc_sq);
         div_neg   = ~acc_sq[IW-1];
      end else if (cmd.edge_div_start) begin
         div_start = 1'b1;
      end
   end

   assign amx = req_coord_x[COORD_WIDTH-1] ? COORD_WIDTH'(-req_coord_x) : req_coord_x;
   assign amy = req_coord_y[COORD_WIDTH-1] ? COORD_WIDTH'(-req_coord_y) : req_coord_y;
   assign amz = req_coord_z[COORD_WIDTH-1] ? COORD_WIDTH'(-req_coord_z) : req_coord_z;
   assign hit = live_ff && parity_ff;

   // Control state and the registers with a defined reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff    <= '{default: '0};
         dir_ff       <= '{coord_type'(1) <<< FRAC_BITS, '0, '0};
         normal_ff    <= '{default: '0};
         best_pt_ff   <= '{default: '0};
         cur_tag_ff   <= '0;
         best_tag_ff  <= '0;
         best_dist_ff <= '1;
         axis_ff      <= '0;
         parity_ff    <= 1'b0;
         live_ff      <= 1'b0;
         await_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_ORIGIN_X: origin_ff[0] <= csr_write_data;
               CSR_ORIGIN_Y: origin_ff[1] <= csr_write_data;
               CSR_ORIGIN_Z: origin_ff[2] <= csr_write_data;
               CSR_DIR_X:    dir_ff[0]    <= csr_write_data;
               CSR_DIR_Y:    dir_ff[1]    <= csr_write_data;
               CSR_DIR_Z:    dir_ff[2]    <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.clear) begin
            best_dist_ff <= '1;
            best_pt_ff   <= '{default: '0};
            best_tag_ff  <= '0;
         end
         if (cmd.header) begin
            normal_ff  <= cur_ff;
            cur_tag_ff <= in_tag_ff;
            await_ff   <= 1'b1;
            parity_ff  <= 1'b0;
            live_ff    <= 1'b0;
            axis_ff    <= axis_next_ff;
         end
         if (cmd.load_first) begin
            await_ff  <= 1'b0;
            parity_ff <= 1'b0;
            live_ff   <= 1'b0;
         end
         if (cmd.set_live) live_ff <= 1'b1;
         if ((cmd.edge_eval && kind == EDGE_TOGGLE) || (cmd.edge_side && side > AW'(1)))
            parity_ff <= ~parity_ff;
         if (cmd.commit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.commit) begin
            await_ff     <= 1'b1;
            live_ff      <= 1'b0;
            parity_ff    <= 1'b0;
            if (hit) begin
               best_dist_ff <= dist_ff[COORD_WIDTH-2:0];
               best_pt_ff   <= point_ff;
               best_tag_ff  <= cur_tag_ff;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cur_ff       <= '{req_coord_x, req_coord_y, req_coord_z};
         last_ff      <= req_last_vertex;
         in_tag_ff    <= req_face_tag;
         axis_next_ff <= (amx >= amy && amx >= amz) ? 2'd0 : ((amy >= amz) ? 2'd1 : 2'd2);
      end
      if (cmd.load_first) begin
         first_ff <= cur_ff;
         prev_ff  <= cur_ff;
      end
      if (cmd.advance) prev_ff <= cur_ff;
      if (cmd.mul_issue || cmd.edge_mul) begin
         prod_ff     <= MW'(mag_diff(ma)) * MW'(mag_diff(mb));
         prod_neg_ff <= ma[DW-1] ^ mb[DW-1];
      end
      if (cmd.acc_clear) acc_ff <= '0;
      else if (cmd.acc_take && cmd.mul_mode != MUL_P) acc_ff <= acc_ff + AW'(fm);
      if (cmd.acc_take && cmd.mul_mode == MUL_P)
         point_ff[ti] <= sat_coord((IW+1)'(fm) + (IW+1)'(origin_ff[ti]));
      if (cmd.chk_d) dist_ff <= acc_sq;
      if (cmd.chk_t) dist_ff <= quot;
      if (cmd.commit) begin
         rsp_new_best_ff <= hit;
         rsp_dist_ff     <= hit ? dist_ff[COORD_WIDTH-2:0] : best_dist_ff;
         rsp_pt_ff       <= hit ? point_ff : best_pt_ff;
         rsp_tag_ff      <= hit ? cur_tag_ff : best_tag_ff;
      end
   end

   always_comb begin
      stat             = '0;
      stat.await_first = await_ff;
      stat.live        = live_ff;
      stat.last        = last_ff;
      stat.d_pos       = !acc_sq[IW-1] && acc_sq != '0;
      stat.n_nz        = acc_sq != '0;
      stat.t_ok        = !quot[IW-1] && quot != '0 &&
                         quot < $signed(IW'(best_dist_ff));
      stat.edge_kind   = kind;
      stat.div_done    = div_done;
      stat.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_best   = rsp_new_best_ff;
   assign rsp_best_dist  = rsp_dist_ff;
   assign rsp_best_hit_x = rsp_pt_ff[0];
   assign rsp_best_hit_y = rsp_pt_ff[1];
   assign rsp_best_hit_z = rsp_pt_ff[2];
   assign rsp_best_face  = rsp_tag_ff;

endmodule

FILE: hdl/rpi_checker.sv
// Port-level assertions for the intersect block, bound to the top level.
`timescale 1ns / 1ps
module rpi_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_new_best,
   input logic [rpi_pkg::COORD_WIDTH-2:0] rsp_best_dist,
   input logic [rpi_pkg::TAG_WIDTH-1:0]   rsp_best_face
);
   import rpi_pkg::*;

   // No response may be pending right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_dist) &&
      $stable(rsp_best_face))
      else $error("stalled response changed");

   // A new best hit always carries a real distance.
   a_best_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_best |-> (|(~rsp_best_dist)))
      else $error("new best without a distance");

   // One request at a time: ready drops after each accept.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

endmodule

bind ray_polygon_intersect rpi_checker u_rpi_checker (.*);
